### src/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip assertion failed");

// next-cycle implication, disabled in reset
`define PIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pip assertion failed");

`endif

### src/pip_pkg.sv
// package for the point-in-polygon block: sizes, state encoding, edge unit interface
// no dependencies
package pip_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W        = 5;
  localparam int SLOT_W       = 4;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TEST  = 1'b1;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = CFG_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } pip_state_e;

  typedef struct packed {
    logic                  valid;
    logic                  clr;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [COORD_BITS-1:0] pt_x;
    logic [COORD_BITS-1:0] pt_y;
  } pip_edge_req_t;

  typedef struct packed {
    logic busy;
    logic parity;
  } pip_edge_sts_t;

endpackage

### src/pip_edge.sv
// edge crossing unit: differences, exact cross-multiplied compare, parity
// depends on pip_pkg
module pip_edge import pip_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pip_edge_req_t req_i,
  output pip_edge_sts_t sts_o
);

  logic                     v1_q, v1_d;
  logic                     v2_q, v2_d;
  logic                     parity_q, parity_d;
  logic                     dypos1_q, dypos2_q;
  logic signed [DIFF_W-1:0] lx_q, dy_q, ry_q, dx_q;
  logic signed [PROD_W-1:0] p1_q, p2_q;

  logic signed [DIFF_W-1:0] x1, y1, x2, y2, px, py;
  logic signed [DIFF_W-1:0] dy, lx, ry, dx;
  logic                     straddle, left;

  assign x1 = DIFF_W'($signed(req_i.cur_x));
  assign y1 = DIFF_W'($signed(req_i.cur_y));
  assign x2 = DIFF_W'($signed(req_i.prev_x));
  assign y2 = DIFF_W'($signed(req_i.prev_y));
  assign px = DIFF_W'($signed(req_i.pt_x));
  assign py = DIFF_W'($signed(req_i.pt_y));

  assign dy = y2 - y1;
  assign lx = px - x1;
  assign ry = py - y1;
  assign dx = x2 - x1;
  assign straddle = (py > y1) != (py > y2);

  assign left = dypos2_q ? (p1_q < p2_q) : (p2_q < p1_q);

  always_comb begin
    v1_d     = req_i.valid & straddle;
    v2_d     = v1_q;
    parity_d = parity_q;
    if (req_i.clr) begin
      parity_d = 1'b0;
    end else if (v2_q && left) begin
      parity_d = ~parity_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dypos1_q <= dy > 0;
    lx_q     <= lx;
    dy_q     <= dy;
    ry_q     <= ry;
    dx_q     <= dx;
    dypos2_q <= dypos1_q;
    p1_q     <= lx_q * dy_q;
    p2_q     <= ry_q * dx_q;
  end

  assign sts_o.busy   = v1_q | v2_q;
  assign sts_o.parity = parity_q;

endmodule

### src/point_in_polygon_ray_cast_top.sv
// point-in-polygon top: vertex table, edge-walk sequencer, config register
// depends on pip_pkg and pip_edge
// a test walks the edges of the n vertices in use (n = vertex_count, capped at 16): prime,
// walk, drain until the edge unit is idle, then the done strobe; with n = 0 it goes to drain
// busy_o stays high through the strobe, so a new test is only accepted after it; no stall
// a vertex write leaves the block idle; reset sets vertex_count to 4, the table is not cleared
module point_in_polygon_ray_cast_top import pip_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [SLOT_W-1:0]            vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         done_o,
  output logic                         inside_res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_W-1:0]             cfg_data_i
);

  logic [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  pip_state_e            state_q, state_d;
  logic [VIDX_W-1:0]     idx_q, idx_d;
  logic [CFG_W-1:0]      vcount_q;
  logic                  rd_prime_q, rd_prime_d;
  logic                  rd_edge_q, rd_edge_d;
  logic [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] pt_x_q, pt_y_q;

  logic [CNT_W-1:0]  n_use, n_last;
  logic [VIDX_W-1:0] rd_addr;
  logic              accept, wr_en, clr;
  pip_edge_req_t     edge_req;
  pip_edge_sts_t     edge_sts;

  assign accept = start_i & ~busy_o;
  assign wr_en  = accept & (kind_i == KIND_WRITE) & (int'(vertex_index_i) < MAX_VERTICES);
  assign n_use  = (int'(vcount_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount_q);
  assign n_last = n_use - CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KIND_TEST) begin
          state_d = (n_use == '0) ? ST_DRAIN : ST_PRIME;
        end
      end
      ST_PRIME: state_d = ST_WALK;
      ST_WALK: begin
        if (CNT_W'(idx_q) == n_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_edge_q && !edge_sts.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idx_d      = idx_q;
    rd_prime_d = 1'b0;
    rd_edge_d  = 1'b0;
    rd_addr    = idx_q;
    clr        = 1'b0;
    busy_o     = 1'b1;
    done_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        clr    = accept;
      end
      ST_PRIME: begin
        rd_addr    = VIDX_W'(n_last);
        rd_prime_d = 1'b1;
        idx_d      = '0;
      end
      ST_WALK: begin
        rd_edge_d = 1'b1;
        idx_d     = idx_q + VIDX_W'(1);
      end
      ST_DRAIN: ;
      ST_DONE:  done_o = 1'b1;
      default:  ;
    endcase
  end

  assign inside_res_o = edge_sts.parity;
  assign cfg_ready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      rd_prime_q <= 1'b0;
      rd_edge_q  <= 1'b0;
      vcount_q   <= VERTEX_COUNT_RST;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_prime_q <= rd_prime_d;
      rd_edge_q  <= rd_edge_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // vertex table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[VIDX_W'(vertex_index_i)] <= coord_x_i;
      mem_y[VIDX_W'(vertex_index_i)] <= coord_y_i;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_x_q <= coord_x_i;
      pt_y_q <= coord_y_i;
    end
    if (rd_prime_q || rd_edge_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
  end

  assign edge_req.valid  = rd_edge_q;
  assign edge_req.clr    = clr;
  assign edge_req.cur_x  = rd_x_q;
  assign edge_req.cur_y  = rd_y_q;
  assign edge_req.prev_x = prev_x_q;
  assign edge_req.prev_y = prev_y_q;
  assign edge_req.pt_x   = pt_x_q;
  assign edge_req.pt_y   = pt_y_q;

  pip_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (edge_req),
    .sts_o  (edge_sts)
  );

endmodule

### src/pip_chk.sv
// port-level checker for the point-in-polygon top, attached by bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module pip_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic kind_i,
  input logic done_o
);

  `PIP_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `PIP_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o && !done_o)
  `PIP_ASSERT_NXT(a_test_busy, clk_i, rst_ni, start_i && !busy_o && kind_i, busy_o && !done_o)
  `PIP_ASSERT_NXT(a_write_free, clk_i, rst_ni, start_i && !busy_o && !kind_i, !busy_o && !done_o)

endmodule

bind point_in_polygon_ray_cast_top pip_chk u_pip_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .kind_i  (kind_i),
  .done_o  (done_o)
);

### bench/point_in_polygon_ray_cast_top_tb.sv
// testbench for point_in_polygon_ray_cast_top: directed table, then random polygons and queries
// uses pip_pkg for sizes and kind codes; results are checked against table values or an in-bench ray-cast predictor
`timescale 1ns / 1ps

module point_in_polygon_ray_cast_top_tb;
  import pip_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 140;
  localparam int SETTLE       = 30;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_W-1:0]     idx;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  has_exp;
    logic                  exp_val;
  } stim_row_t;

  localparam stim_row_t DIR_TBL [0:22] = '{
    '{KIND_WRITE, 4'd0,  -16'sd256,   -16'sd256,   1'b0, 1'b0},
    '{KIND_WRITE, 4'd1,  16'sd256,    -16'sd256,   1'b0, 1'b0},
    '{KIND_WRITE, 4'd2,  16'sd256,    16'sd256,    1'b0, 1'b0},
    '{KIND_WRITE, 4'd3,  -16'sd256,   16'sd256,    1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd0,      16'sd0,      1'b1, 1'b1},
    '{KIND_TEST,  4'd0,  16'sd1000,   16'sd0,      1'b1, 1'b0},
    '{KIND_TEST,  4'd0,  -16'sd256,   16'sd0,      1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd256,    16'sd0,      1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd0,      -16'sd256,   1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd0,      16'sd256,    1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  -16'sd256,   -16'sd256,   1'b0, 1'b0},
    '{KIND_TEST,  4'd15, 16'sd0,      16'sd0,      1'b1, 1'b1},
    '{KIND_WRITE, 4'd15, 16'sd32767,  -16'sd32768, 1'b0, 1'b0},
    '{KIND_WRITE, 4'd0,  -16'sd32768, -16'sd32768, 1'b0, 1'b0},
    '{KIND_WRITE, 4'd1,  16'sd32767,  -16'sd32768, 1'b0, 1'b0},
    '{KIND_WRITE, 4'd2,  16'sd32767,  16'sd32767,  1'b0, 1'b0},
    '{KIND_WRITE, 4'd3,  -16'sd32768, 16'sd32767,  1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd0,      16'sd0,      1'b1, 1'b1},
    '{KIND_TEST,  4'd0,  -16'sd32768, -16'sd32768, 1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd32767,  16'sd32767,  1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd32767,  16'sd0,      1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  -16'sd32768, 16'sd0,      1'b0, 1'b0},
    '{KIND_TEST,  4'd0,  16'sd0,      -16'sd32768, 1'b0, 1'b0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic                         kind_i;
  logic [SLOT_W-1:0]            vertex_index_i;
  logic signed [COORD_BITS-1:0] coord_x_i;
  logic signed [COORD_BITS-1:0] coord_y_i;
  logic                         done_o;
  logic                         inside_res_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_W-1:0]             cfg_data_i;

  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  bit                           slot_written [MAX_VERTICES];
  logic [CFG_W-1:0]             poly_count;
  logic                         inside_expect_q [$];
  int                           err_cnt;
  int                           item_cnt;
  int                           cycle_cnt;
  bit                           idle_on;

  point_in_polygon_ray_cast_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .vertex_index_i (vertex_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .done_o         (done_o),
    .inside_res_o   (inside_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // even-odd parity over the edges in use, exact cross-multiplied compare
  function automatic logic ray_cast_inside(input logic signed [COORD_BITS-1:0] px,
                                           input logic signed [COORD_BITS-1:0] py);
    int     n;
    int     j;
    longint x1, y1, x2, y2, dy, lx, ry, dx, qx, qy;
    logic   par;
    logic   left;
    par = 1'b0;
    qx  = longint'(px);
    qy  = longint'(py);
    n   = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    for (int i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      x1 = longint'(poly_x[i]);
      y1 = longint'(poly_y[i]);
      x2 = longint'(poly_x[j]);
      y2 = longint'(poly_y[j]);
      if ((qy > y1) != (qy > y2)) begin
        dy = y2 - y1;
        lx = qx - x1;
        ry = qy - y1;
        dx = x2 - x1;
        if (dy > 0) left = (lx * dy) < (ry * dx);
        else left = (ry * dx) < (lx * dy);
        if (left) par = ~par;
      end
    end
    return par;
  endfunction

  function automatic logic [COORD_BITS-1:0] clip16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_BITS-1:0];
  endfunction

  // one transaction on the command port, with an optional idle burst ahead of it
  task automatic push_item(input logic kind, input logic [SLOT_W-1:0] idx,
                           input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                           input logic has_exp, input logic exp_val);
    int   gap;
    logic val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i        = 1'b1;
    kind_i         = kind;
    vertex_index_i = idx;
    coord_x_i      = x;
    coord_y_i      = y;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (kind == KIND_TEST) begin
      val = has_exp ? exp_val : ray_cast_inside($signed(x), $signed(y));
      inside_expect_q = {inside_expect_q, val};
    end else begin
      poly_x[idx]       = $signed(x);
      poly_y[idx]       = $signed(y);
      slot_written[idx] = 1'b1;
    end
    item_cnt++;
  endtask

  // a query that would read a never-written slot becomes a write of that slot
  task automatic safe_query(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    int n;
    int hole;
    n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    hole = -1;
    for (int k = n - 1; k >= 0; k--) if (!slot_written[k]) hole = k;
    if (hole >= 0) push_item(KIND_WRITE, SLOT_W'(hole), x, y, 1'b0, 1'b0);
    else push_item(KIND_TEST, SLOT_W'($urandom), x, y, 1'b0, 1'b0);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    start_i = 1'b0;
    while (inside_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input logic [CFG_W-1:0] value);
    quiesce();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    poly_count = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // fresh polygon over the slots in use, then queries around it
  task automatic poly_burst();
    int n, span, cx, cy, ntest, r, pick;
    logic [COORD_BITS-1:0] x, y;
    n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    pick = $urandom_range(0, 3);
    span = (pick == 0) ? 64 : (pick == 1) ? 1024 : (pick == 2) ? 8000 : 32767;
    cx   = (span == 32767) ? 0 : int'($urandom_range(0, 2 * (32767 - span))) - (32767 - span);
    cy   = (span == 32767) ? 0 : int'($urandom_range(0, 2 * (32767 - span))) - (32767 - span);
    for (int k = 0; k < n; k++) begin
      x = clip16(cx + int'($urandom_range(0, 2 * span)) - span);
      if ($urandom_range(0, 3) == 0)
        y = clip16(cy + (int'($urandom_range(0, 2)) - 1) * (span / 2));
      else
        y = clip16(cy + int'($urandom_range(0, 2 * span)) - span);
      push_item(KIND_WRITE, SLOT_W'(k), x, y, 1'b0, 1'b0);
    end
    ntest = $urandom_range(3, 8);
    for (int t = 0; t < ntest; t++) begin
      pick = $urandom_range(0, 3);
      r    = (n > 0) ? $urandom_range(0, n - 1) : 0;
      x    = clip16(cx + int'($urandom_range(0, 3 * span)) - (3 * span) / 2);
      y    = clip16(cy + int'($urandom_range(0, 3 * span)) - (3 * span) / 2);
      if (pick == 0 && n > 0) begin
        x = poly_x[r];
        y = poly_y[r];
      end else if (pick == 1 && n > 0) begin
        y = poly_y[r];
      end
      safe_query(x, y);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (inside_expect_q.size() == 0) begin
        note_mismatch($sformatf("result %b with no query outstanding", inside_res_o));
      end else if (inside_res_o !== inside_expect_q[0]) begin
        note_mismatch($sformatf("inside_res expected %b got %b",
                                inside_expect_q[0], inside_res_o));
        void'(inside_expect_q.pop_front());
      end else begin
        void'(inside_expect_q.pop_front());
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] plan [NUM_PHASES];
    int               phase_base;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = KIND_WRITE;
    vertex_index_i = '0;
    coord_x_i      = '0;
    coord_y_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    err_cnt        = 0;
    item_cnt       = 0;
    cycle_cnt      = 0;
    idle_on        = 1'b1;
    poly_count     = VERTEX_COUNT_RST;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      poly_x[k]       = '0;
      poly_y[k]       = '0;
      slot_written[k] = 1'b0;
    end
    plan = '{5'd3, 5'd16, 5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd7,
             CFG_W'($urandom_range(3, 16)), CFG_W'($urandom_range(0, 31)), 5'd4, 5'd12};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_TBL[r])
      push_item(DIR_TBL[r].kind, DIR_TBL[r].idx, DIR_TBL[r].x, DIR_TBL[r].y,
                DIR_TBL[r].has_exp, DIR_TBL[r].exp_val);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_vertex_count(plan[ph]);
      idle_on    = (ph < NUM_PHASES - 2) && ($urandom_range(0, 4) != 0);
      phase_base = item_cnt;
      while (item_cnt - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 1) == 0)
            push_item(KIND_WRITE, SLOT_W'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), 1'b0, 1'b0);
          else
            safe_query(COORD_BITS'($urandom), COORD_BITS'($urandom));
        end else begin
          poly_burst();
        end
      end
    end

    quiesce();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/pip_pkg.sv
src/pip_edge.sv
src/point_in_polygon_ray_cast_top.sv
src/pip_chk.sv
bench/point_in_polygon_ray_cast_top_tb.sv
